/* rtl/cfrr_pkg.sv */
// Shared types, constants and the CRC-8 step for the frame receiver/responder.
package cfrr_pkg;

    localparam logic [7:0] HDR_BYTE          = 8'h5A;
    localparam logic [7:0] CRC_POLY          = 8'h07;
    localparam logic [7:0] FUNC_POWER        = 8'h10;
    localparam logic [7:0] FUNC_SIGNAL       = 8'h11;
    localparam logic [7:0] REPLY_CODE_SIGNAL = 8'h01;
    localparam logic [7:0] REPLY_CODE_POWER  = 8'h02;
    localparam logic [7:0] REPLY_LEN_BYTE    = 8'h05;
    localparam logic [7:0] MIN_LEN           = 8'd4;
    localparam logic [8:0] GAP_MAX           = 9'd511;
    localparam logic [7:0] GAP_LIMIT_RESET   = 8'd50;

    // configuration register indexes
    localparam logic [1:0] REG_GAP_LIMIT  = 2'd0;
    localparam logic [1:0] REG_POWER_EN   = 2'd1;
    localparam logic [1:0] REG_SIGNAL_EN  = 2'd2;

    // reply queue depth, power of two
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [7:0] gap_limit;
        logic       power_en;
        logic       signal_en;
    } cfg_t;

    typedef struct packed {
        logic       is_power;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // one byte into a CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/cfrr_front.sv */
// Frame parser: header hunt, length check, CRC tracking, gap aging, reply requests.
module cfrr_front #(
    parameter int MAX_FRAME_LEN = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               req_type,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         signal_value,
    input  logic [7:0]         power_value,
    input  cfrr_pkg::cfg_t     cfg,
    output logic               push,
    output cfrr_pkg::cmd_t     push_cmd
);
    import cfrr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [7:0] MaxLen8 = 8'(MAX_FRAME_LEN);

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [CW-1:0] frame_length_reg, frame_length_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    func_reg, func_next;
    logic [8:0]    gap_reg, gap_next;

    logic [8:0]    gap_inc;
    logic [CW-1:0] count_inc;
    logic [7:0]    crc_fed;

    assign gap_inc   = (gap_reg == GAP_MAX) ? gap_reg : gap_reg + 9'd1;
    assign count_inc = byte_count_reg + CW'(1);
    assign crc_fed   = crc8_feed((byte_count_reg == '0) ? 8'h00 : crc_reg, rx_byte);

    always_comb begin
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        crc_next          = crc_reg;
        func_next         = func_reg;
        gap_next          = gap_reg;
        push              = 1'b0;
        push_cmd.is_power = 1'b0;
        push_cmd.value    = signal_value;
        if (accept) begin
            if (req_type) begin
                gap_next = gap_inc;
                if (byte_count_reg != '0 && gap_inc > {1'b0, cfg.gap_limit}) begin
                    byte_count_next = '0;
                end
            end else begin
                gap_next = '0;
                if (byte_count_reg == '0) begin
                    if (rx_byte == HDR_BYTE) begin
                        byte_count_next = CW'(1);
                        crc_next        = crc_fed;
                    end
                end else if (byte_count_reg == CW'(1)) begin
                    if (rx_byte < MIN_LEN || rx_byte > MaxLen8) begin
                        byte_count_next = '0;
                    end else begin
                        frame_length_next = CW'(rx_byte);
                        crc_next          = crc_fed;
                        byte_count_next   = CW'(2);
                    end
                end else if (count_inc >= frame_length_reg) begin
                    // CRC byte closes the frame
                    byte_count_next = '0;
                    if (rx_byte == crc_reg) begin
                        if (func_reg == FUNC_POWER && cfg.power_en) begin
                            push              = 1'b1;
                            push_cmd.is_power = 1'b1;
                            push_cmd.value    = power_value;
                        end else if (func_reg == FUNC_SIGNAL && cfg.signal_en) begin
                            push = 1'b1;
                        end
                    end
                end else begin
                    byte_count_next = count_inc;
                    if (byte_count_reg == CW'(2)) begin
                        func_next = rx_byte;
                    end
                    crc_next = crc_fed;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            crc_reg          <= '0;
            func_reg         <= '0;
            gap_reg          <= '0;
        end else begin
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            crc_reg          <= crc_next;
            func_reg         <= func_next;
            gap_reg          <= gap_next;
        end
    end

endmodule

/* rtl/cfrr_queue.sv */
// Small FIFO of pending reply requests between parser and serializer.
module cfrr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cfrr_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output cfrr_pkg::cmd_t     head,
    output cfrr_pkg::qstat_t   stat
);
    import cfrr_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    cmd_t            entries_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign stat.full  = (count_reg == (PW + 1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/cfrr_back.sv */
// Reply serializer: five words per request, CRC built as bytes go out.
module cfrr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfrr_pkg::cmd_t     head,
    input  cfrr_pkg::qstat_t   stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);
    import cfrr_pkg::*;

    localparam logic [2:0] SLOT_HDR   = 3'd0;
    localparam logic [2:0] SLOT_LEN   = 3'd1;
    localparam logic [2:0] SLOT_CODE  = 3'd2;
    localparam logic [2:0] SLOT_VALUE = 3'd3;
    localparam logic [2:0] SLOT_CRC   = 3'd4;

    logic [2:0] slot_reg, slot_next;
    logic [7:0] crc_reg, crc_next;
    logic       xfer;

    assign m_tvalid = !stat.empty;
    assign m_tlast  = (slot_reg == SLOT_CRC);
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && m_tlast;

    always_comb begin
        case (slot_reg)
            SLOT_HDR:   m_tdata = HDR_BYTE;
            SLOT_LEN:   m_tdata = REPLY_LEN_BYTE;
            SLOT_CODE:  m_tdata = head.is_power ? REPLY_CODE_POWER : REPLY_CODE_SIGNAL;
            SLOT_VALUE: m_tdata = head.value;
            SLOT_CRC:   m_tdata = crc_reg;
            default:    m_tdata = crc_reg;
        endcase
    end

    always_comb begin
        slot_next = slot_reg;
        crc_next  = crc_reg;
        if (xfer) begin
            if (m_tlast) begin
                slot_next = SLOT_HDR;
                crc_next  = '0;
            end else begin
                slot_next = slot_reg + 3'd1;
                crc_next  = crc8_feed(crc_reg, m_tdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= SLOT_HDR;
            crc_reg  <= '0;
        end else begin
            slot_reg <= slot_next;
            crc_reg  <= crc_next;
        end
    end

endmodule

/* rtl/crc8_frame_receiver_responder.sv */
// Top level: config registers, frame parser, reply queue and serializer.
// Throughput: one input word per cycle; s_tready drops only while the reply queue is full.
// A reply request is queued when its CRC byte is accepted and waits behind earlier replies.
// Each reply is five back-to-back words; the serializer's byte slot counter sets that.
// Reset: synchronous active-low aresetn; parser hunts for a header, queue empty,
// gap limit 50, both reply enables off.
module crc8_frame_receiver_responder #(
    parameter int MAX_FRAME_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte, signal_value, power_value
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import cfrr_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    cmd_t   push_cmd, head;
    qstat_t stat;
    logic   push, pop, s_accept;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_GAP_LIMIT: cfg_next.gap_limit = cfg_data;
                REG_POWER_EN:  cfg_next.power_en  = cfg_data[0];
                REG_SIGNAL_EN: cfg_next.signal_en = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_limit <= GAP_LIMIT_RESET;
            cfg_reg.power_en  <= 1'b0;
            cfg_reg.signal_en <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !stat.full;
    assign s_accept = s_tvalid && s_tready;

    cfrr_front #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .req_type     (s_tuser),
        .rx_byte      (s_tdata[7:0]),
        .signal_value (s_tdata[15:8]),
        .power_value  (s_tdata[23:16]),
        .cfg          (cfg_reg),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    cfrr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    cfrr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a reply request only comes from an accepted data byte
    a_push_on_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_tvalid && s_tready && !s_tuser))
        else $error("reply request without an accepted data byte");

    // never write a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("reply queue overflow");

    // a reply frame is never broken up once started
    a_reply_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("reply frame interrupted");

    // queue only drains at the end of a frame
    a_pop_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (m_tlast && m_tready && !stat.empty))
        else $error("queue popped mid-frame");

endmodule
